/* rtl/integer_matrix_multiply_unit_assert.svh */
// Assertion macros for the integer matrix multiply unit
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define IMM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IMM_ASSERT_IMPL(label, ante, cons, msg)
`define IMM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/imm_pkg.sv */
// Shared types, constants and the size clamp function of the integer matrix multiply unit
package imm_pkg;

  localparam int DIM_W       = 4;
  localparam int OUT_W       = 35;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0] rows_a;
    logic [DIM_W-1:0] inner_dim;
    logic [DIM_W-1:0] cols_b;
  } dims_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic first;
    logic last_l;
    logic row_end;
    logic fin;
  } tag_t;

  typedef enum logic {
    BK_LOAD,
    BK_RUN
  } back_state_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/imm_front.sv */
// Front end: size registers, load position tracking and queue entry build
module imm_front #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int IDX_W      = 3,
  parameter int ADDR_W     = 6,
  parameter int ENTRY_W    = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic signed [ELEM_WIDTH-1:0]    element,
  input  logic                            cfg_write,
  input  logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]       cfg_data,
  output imm_pkg::dims_t                  dims,
  output logic                            push,
  output logic [ENTRY_W-1:0]              push_data
);
  import imm_pkg::*;

  localparam logic [DIM_W-1:0] MAX_SIZE = DIM_W'(MAX_DIM);

  dims_t            dims_next;
  logic             phase_b;
  logic [IDX_W-1:0] row;
  logic [IDX_W-1:0] col;
  logic [DIM_W-1:0] row_lim;
  logic [DIM_W-1:0] col_lim;
  logic             col_wrap;
  logic             row_wrap;
  logic             cfg_hit;
  logic [ADDR_W-1:0] addr;

  always_comb begin
    dims_next = dims;
    cfg_hit   = 1'b0;
    if (cfg_write) begin
      case (cfg_index)
        REG_ROWS_A: begin
          dims_next.rows_a = clamp_size(cfg_data, MAX_SIZE);
          cfg_hit = 1'b1;
        end
        REG_INNER_DIM: begin
          dims_next.inner_dim = clamp_size(cfg_data, MAX_SIZE);
          cfg_hit = 1'b1;
        end
        REG_COLS_B: begin
          dims_next.cols_b = clamp_size(cfg_data, MAX_SIZE);
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    row_lim  = phase_b ? dims.inner_dim : dims.rows_a;
    col_lim  = phase_b ? dims.cols_b : dims.inner_dim;
    col_wrap = (DIM_W'(col) == col_lim - DIM_W'(1));
    row_wrap = (DIM_W'(row) == row_lim - DIM_W'(1));
    addr     = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
  end

  assign push      = accept;
  assign push_data = {phase_b, phase_b & col_wrap & row_wrap, addr, element};

  always_ff @(posedge clk) begin
    if (rst) begin
      dims    <= '{rows_a: MAX_SIZE, inner_dim: MAX_SIZE, cols_b: MAX_SIZE};
      phase_b <= 1'b0;
      row     <= '0;
      col     <= '0;
    end else begin
      dims <= dims_next;
      if (cfg_hit) begin
        phase_b <= 1'b0;
        row     <= '0;
        col     <= '0;
      end else if (accept) begin
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row     <= '0;
            phase_b <= ~phase_b;
          end else begin
            row <= row + IDX_W'(1);
          end
        end else begin
          col <= col + IDX_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/imm_queue.sv */
// Short queue between front end and back end
module imm_queue #(
  parameter int DATA_W = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [DATA_W-1:0]      push_data,
  input  logic                   pop,
  output logic [DATA_W-1:0]      pop_data,
  output imm_pkg::queue_status_t status
);
  import imm_pkg::*;

  logic [DATA_W-1:0] slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

/* rtl/imm_back.sv */
// Back end: element stores, dot product sequencer and multiply-accumulate pipeline
module imm_back #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16,
  parameter int IDX_W      = 3,
  parameter int ADDR_W     = 6,
  parameter int ENTRY_W    = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  imm_pkg::dims_t                    dims,
  input  imm_pkg::queue_status_t            q_status,
  input  logic [ENTRY_W-1:0]                q_data,
  output logic                              pop,
  output logic                              result_valid,
  output logic signed [imm_pkg::OUT_W-1:0]  product_entry,
  output logic                              row_end,
  output logic                              last
);
  import imm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_WIDTH;

  logic [ELEM_WIDTH-1:0] mem_a [DEPTH];
  logic [ELEM_WIDTH-1:0] mem_b [DEPTH];

  back_state_t state;
  back_state_t state_next;

  logic                  e_is_b;
  logic                  e_last;
  logic [ADDR_W-1:0]     e_addr;
  logic [ELEM_WIDTH-1:0] e_elem;

  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] l;
  logic             issue;
  logic             l_end;
  logic             k_end;
  logic             j_end;
  logic             issue_final;
  tag_t             tag0;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;

  logic                         v1;
  tag_t                         tag1;
  logic signed [ELEM_WIDTH-1:0] a_rd;
  logic signed [ELEM_WIDTH-1:0] b_rd;
  logic                         v2;
  tag_t                         tag2;
  logic signed [PROD_W-1:0]     prod;
  logic signed [OUT_W-1:0]      acc;
  logic signed [OUT_W-1:0]      acc_next;

  assign {e_is_b, e_last, e_addr, e_elem} = q_data;

  always_comb begin
    state_next = state;
    case (state)
      BK_LOAD: begin
        if (pop && e_last) begin
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue_final) begin
          state_next = BK_LOAD;
        end
      end
      default: begin
        state_next = BK_LOAD;
      end
    endcase
  end

  always_comb begin
    pop   = 1'b0;
    issue = 1'b0;
    case (state)
      BK_LOAD: begin
        pop = ~q_status.empty;
      end
      BK_RUN: begin
        issue = 1'b1;
      end
      default: begin
        pop   = 1'b0;
        issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    l_end        = (DIM_W'(l) == dims.inner_dim - DIM_W'(1));
    k_end        = (DIM_W'(k) == dims.cols_b - DIM_W'(1));
    j_end        = (DIM_W'(j) == dims.rows_a - DIM_W'(1));
    issue_final  = issue & l_end & k_end & j_end;
    tag0.first   = (l == '0);
    tag0.last_l  = l_end;
    tag0.row_end = k_end;
    tag0.fin     = k_end & j_end;
    a_addr       = ADDR_W'(j) * ADDR_W'(MAX_DIM) + ADDR_W'(l);
    b_addr       = ADDR_W'(l) * ADDR_W'(MAX_DIM) + ADDR_W'(k);
    acc_next     = (tag2.first ? '0 : acc) + OUT_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (pop && !e_is_b) begin
      mem_a[e_addr] <= e_elem;
    end
    if (pop && e_is_b) begin
      mem_b[e_addr] <= e_elem;
    end
    a_rd <= mem_a[a_addr];
    b_rd <= mem_b[b_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_LOAD;
      j     <= '0;
      k     <= '0;
      l     <= '0;
    end else begin
      state <= state_next;
      if (issue) begin
        if (l_end) begin
          l <= '0;
          if (k_end) begin
            k <= '0;
            j <= j_end ? '0 : j + IDX_W'(1);
          end else begin
            k <= k + IDX_W'(1);
          end
        end else begin
          l <= l + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= issue;
      v2           <= v1;
      result_valid <= v2 & tag2.last_l;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tag0;
    tag2 <= tag1;
    prod <= a_rd * b_rd;
    if (v2) begin
      acc <= acc_next;
    end
    if (v2 && tag2.last_l) begin
      product_entry <= acc_next;
      row_end       <= tag2.row_end;
      last          <= tag2.fin;
    end
  end

endmodule

/* rtl/integer_matrix_multiply_unit.sv */
// Integer matrix multiply unit: top level
// Elements of A and then B are taken one per cycle while busy is low. The
// element that completes B starts the product: each entry accumulates inner_dim
// products on one shared multiply-accumulate pipe, one entry after another once
// the dot product sequencer starts. Entries leave in row-major order on
// result_valid, one cycle each, and cannot be held off. A two-item queue sits
// between the element front end and the compute back end; busy rises when it
// fills while a product is being computed. Size writes clamp 0 to 1 and values
// above MAX_DIM to MAX_DIM, and restart the load.
module integer_matrix_multiply_unit #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ELEM_WIDTH-1:0]      element,
  output logic                              result_valid,
  output logic signed [imm_pkg::OUT_W-1:0]  product_entry,
  output logic                              row_end,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [imm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]         cfg_data
);
  import imm_pkg::*;

`include "integer_matrix_multiply_unit_assert.svh"

  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int ENTRY_W = 2 + ADDR_W + ELEM_WIDTH;

  dims_t              dims;
  queue_status_t      q_status;
  logic               accept;
  logic               q_push;
  logic [ENTRY_W-1:0] q_push_data;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_pop_data;

  assign busy   = q_status.full;
  assign accept = start & ~busy;

  imm_front #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .IDX_W      (IDX_W),
    .ADDR_W     (ADDR_W),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .element   (element),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dims      (dims),
    .push      (q_push),
    .push_data (q_push_data)
  );

  imm_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  imm_back #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH),
    .IDX_W      (IDX_W),
    .ADDR_W     (ADDR_W),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .dims          (dims),
    .q_status      (q_status),
    .q_data        (q_pop_data),
    .pop           (q_pop),
    .result_valid  (result_valid),
    .product_entry (product_entry),
    .row_end       (row_end),
    .last          (last)
  );

  `IMM_ASSERT_IMPL(a_last_ends_row, result_valid && last, row_end, "final item not a row end")
  `IMM_ASSERT_NEXT(a_gap_after_last, result_valid && last, !result_valid, "item after final item")
  `IMM_ASSERT_IMPL(a_pop_nonempty, q_pop, !q_status.empty, "queue popped while empty")

endmodule

/* sim/integer_matrix_multiply_checker.sv */
// Checker for the integer matrix multiply unit: predicts product entries and compares them
module integer_matrix_multiply_checker #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic                                 busy,
  input  logic signed [ELEM_WIDTH-1:0]         element,
  input  logic                                 result_valid,
  input  logic signed [imm_pkg::OUT_W-1:0]     product_entry,
  input  logic                                 row_end,
  input  logic                                 last,
  input  logic                                 cfg_write,
  input  logic [imm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [imm_pkg::DIM_W-1:0]            cfg_data,
  output int                                   mismatches,
  output int                                   outstanding,
  output int                                   entries_seen
);

  typedef struct packed {
    logic [imm_pkg::OUT_W-1:0] value;
    logic                      row_end;
    logic                      last;
  } entry_t;

  logic signed [ELEM_WIDTH-1:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] mat_b [MAX_DIM*MAX_DIM];
  int unsigned                  loaded;
  int unsigned                  n_rows;
  int unsigned                  n_inner;
  int unsigned                  n_cols;
  entry_t                       due_entries[$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    entries_seen = 0;
  end

  function automatic int unsigned fit_size(input logic [imm_pkg::DIM_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %0s", $realtime, msg);
    mismatches++;
  endtask

  // store one element; the element that completes B queues the whole product
  task automatic take_element(input logic signed [ELEM_WIDTH-1:0] e);
    int unsigned size_a;
    int unsigned total;
    int unsigned pos;
    longint      acc;
    entry_t      ent;
    size_a = n_rows * n_inner;
    total  = size_a + n_inner * n_cols;
    if (loaded >= total) loaded = 0;
    pos = loaded;
    if (pos < size_a) begin
      mat_a[(pos / n_inner) * MAX_DIM + pos % n_inner] = e;
    end else begin
      pos = pos - size_a;
      mat_b[(pos / n_cols) * MAX_DIM + pos % n_cols] = e;
    end
    if (loaded + 1 < total) begin
      loaded++;
      return;
    end
    loaded = 0;
    for (int unsigned r = 0; r < n_rows; r++) begin
      for (int unsigned c = 0; c < n_cols; c++) begin
        acc = 0;
        for (int unsigned k = 0; k < n_inner; k++) begin
          acc += longint'(mat_a[r * MAX_DIM + k]) * longint'(mat_b[k * MAX_DIM + c]);
        end
        ent.value   = imm_pkg::OUT_W'(acc);
        ent.row_end = (c + 1 == n_cols);
        ent.last    = (r + 1 == n_rows) && (c + 1 == n_cols);
        due_entries.push_back(ent);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    entry_t want;
    if (rst) begin
      loaded  = 0;
      n_rows  = MAX_DIM;
      n_inner = MAX_DIM;
      n_cols  = MAX_DIM;
      due_entries.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          imm_pkg::REG_ROWS_A: begin
            n_rows = fit_size(cfg_data);
            loaded = 0;
          end
          imm_pkg::REG_INNER_DIM: begin
            n_inner = fit_size(cfg_data);
            loaded  = 0;
          end
          imm_pkg::REG_COLS_B: begin
            n_cols = fit_size(cfg_data);
            loaded = 0;
          end
          default: ;
        endcase
      end
      if (start && !busy) take_element(element);
      if (result_valid) begin
        entries_seen++;
        if (due_entries.size() == 0) begin
          report($sformatf("unexpected product entry %0d", product_entry));
        end else begin
          want = due_entries.pop_front();
          if (product_entry !== want.value)
            report($sformatf("entry %0d: product_entry %0d, expected %0d", entries_seen,
                             product_entry, $signed(want.value)));
          if (row_end !== want.row_end)
            report($sformatf("entry %0d: row_end %b, expected %b", entries_seen,
                             row_end, want.row_end));
          if (last !== want.last)
            report($sformatf("entry %0d: last %b, expected %b", entries_seen,
                             last, want.last));
        end
      end
    end
    outstanding <= due_entries.size();
  end

endmodule

/* sim/tb_integer_matrix_multiply_unit.sv */
// Testbench top for the integer matrix multiply unit: stimulus, size settings and verdict
module tb_integer_matrix_multiply_unit;
  import imm_pkg::*;

  localparam int MAX_DIM       = 8;
  localparam int ELEM_WIDTH    = 16;
  localparam int TARGET_ITEMS  = 480;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic signed [ELEM_WIDTH-1:0]   element = '0;
  logic                           cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]           cfg_index = REG_ROWS_A;
  logic [DIM_W-1:0]               cfg_data = '0;
  logic                           busy;
  logic                           result_valid;
  logic signed [OUT_W-1:0]        product_entry;
  logic                           row_end;
  logic                           last;

  int mismatches;
  int outstanding;
  int entries_seen;
  int cycles = 0;
  int sent = 0;
  int size_writes = 0;
  int idle_pct = 0;
  int rows_now = MAX_DIM;
  int inner_now = MAX_DIM;
  int cols_now = MAX_DIM;
  int idle_table[4] = '{0, 50, 0, 19};

  integer_matrix_multiply_unit #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .element      (element),
    .result_valid (result_valid),
    .product_entry(product_entry),
    .row_end      (row_end),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  integer_matrix_multiply_checker #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .element      (element),
    .result_valid (result_valid),
    .product_entry(product_entry),
    .row_end      (row_end),
    .last         (last),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .entries_seen (entries_seen)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_integer_matrix_multiply_unit failed");
      $finish;
    end
  end

  function automatic logic signed [ELEM_WIDTH-1:0] pick_element();
    case ($urandom_range(0, 7))
      0: return ELEM_WIDTH'(-32768);
      1: return ELEM_WIDTH'(32767);
      default: return ELEM_WIDTH'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_size();
    if ($urandom_range(0, 7) == 0) return DIM_W'($urandom_range(0, 15));
    return DIM_W'($urandom_range(1, 4));
  endfunction

  // hold start high until the item is taken; idle first at the phase's rate
  task automatic send_element(input logic signed [ELEM_WIDTH-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    element <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic send_elements(input int count);
    repeat (count) send_element(pick_element());
  endtask

  // drop start and wait until every product entry is out and the pipe is quiet
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    int eff;
    eff = (val == 0) ? 1 : ((val > MAX_DIM) ? MAX_DIM : int'(val));
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ROWS_A:    rows_now = eff;
      REG_INNER_DIM: inner_now = eff;
      REG_COLS_B:    cols_now = eff;
      default: ;
    endcase
    if (idx != REG_UNUSED) size_writes++;
  endtask

  initial begin
    int phase;
    int loads;
    int total;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_size(REG_ROWS_A, 4'd1);
    write_size(REG_INNER_DIM, 4'd1);
    write_size(REG_COLS_B, 4'd1);
    send_element(ELEM_WIDTH'(-32768));
    send_element(ELEM_WIDTH'(-32768));
    send_element(ELEM_WIDTH'(-32768));
    send_element(ELEM_WIDTH'(32767));
    settle();

    // zero and oversized writes clamp: 1x8 by 8x1 of the most negative element
    write_size(REG_ROWS_A, 4'd0);
    write_size(REG_INNER_DIM, 4'd9);
    write_size(REG_COLS_B, 4'd0);
    repeat (16) send_element(ELEM_WIDTH'(-32768));
    settle();

    // a write to the spare index leaves the load where it was
    write_size(REG_INNER_DIM, 4'd1);
    send_element(ELEM_WIDTH'(32767));
    settle();
    write_size(REG_UNUSED, 4'd5);
    send_element(ELEM_WIDTH'(-32767));
    settle();

    // a size write in the middle of a load restarts it
    send_element(ELEM_WIDTH'(12345));
    settle();
    write_size(REG_COLS_B, 4'd1);
    send_element(ELEM_WIDTH'(-1));
    send_element(ELEM_WIDTH'(-32768));
    settle();

    phase = 0;
    while (sent < TARGET_ITEMS) begin
      idle_pct = idle_table[phase % 4];
      if (phase == 0) begin
        write_size(REG_ROWS_A, 4'd8);
        write_size(REG_INNER_DIM, 4'd15);
        write_size(REG_COLS_B, 4'd12);
        loads = 1;
      end else begin
        write_size(REG_ROWS_A, pick_size());
        write_size(REG_INNER_DIM, pick_size());
        write_size(REG_COLS_B, pick_size());
        loads = $urandom_range(1, 3);
      end
      repeat (loads) begin
        if ($urandom_range(0, 9) == 0) begin
          total = rows_now * inner_now + inner_now * cols_now;
          send_elements($urandom_range(1, total - 1));
          settle();
          write_size(CFG_IDX_W'($urandom_range(0, 2)), pick_size());
        end
        send_elements(rows_now * inner_now + inner_now * cols_now);
      end
      settle();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d elements, %0d product entries, %0d size writes over %0d phases",
             sent, entries_seen, size_writes, phase);
    if (mismatches == 0) begin
      $display("tb_integer_matrix_multiply_unit passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_integer_matrix_multiply_unit failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/imm_pkg.sv
rtl/imm_front.sv
rtl/imm_queue.sv
rtl/imm_back.sv
rtl/integer_matrix_multiply_unit.sv
sim/integer_matrix_multiply_checker.sv
sim/tb_integer_matrix_multiply_unit.sv
